// ===== hdl/fpfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator package
// Shared codes, field widths and word types of the allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int OP_W        = 2;
    localparam int IDX_FIELD_W = 6;
    localparam int SIZE_W      = 16;
    localparam int TOTAL_W     = 22;
    localparam int COUNT_W     = 16;
    localparam int STRAT_W     = 2;
    localparam int BCOUNT_W    = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_STRATEGY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 22'h3FFFFF;
    localparam logic [COUNT_W-1:0] REFUSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [IDX_FIELD_W-1:0] block_index;
        logic [SIZE_W-1:0]      size;
    } in_word_t;

    typedef struct packed {
        logic                   granted;
        logic [IDX_FIELD_W-1:0] granted_block;
        logic [SIZE_W-1:0]      fragmentation;
        logic [TOTAL_W-1:0]     total_fragmentation;
        logic [COUNT_W-1:0]     unallocated_count;
    } out_word_t;

    typedef struct packed {
        logic item_take;
        logic scan_step;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

// ===== hdl/fpfa_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator item channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface fpfa_item_if
    import fpfa_pkg::*;
;
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fpfa_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface fpfa_result_if
    import fpfa_pkg::*;
;
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fpfa_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator configuration channel
// Valid/ready write channel with a register index and write data.
// ----------------------------------------------------------------------------
interface fpfa_cfg_if
    import fpfa_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fixed_partition_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator
// Places size requests in free table partitions by best, first or worst fit.
// ----------------------------------------------------------------------------
// Load, clear and unused operations go from intake straight to commit, where the
// result word is registered; a request first scans min(block_count, MAX_BLOCKS)
// partitions, one read of the partition size memory per cycle. Commit waits while
// an earlier result is not yet taken, and a new word is taken only after commit.
// Reset clears configuration, occupancy and totals; partition sizes hold no value
// until loaded.
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
)
(
    input logic           clk,
    input logic           rst_n,
    fpfa_item_if.sink     item,
    fpfa_result_if.source result,
    fpfa_cfg_if.sink      cfg
);

    ctl_cmd_t cmd;
    dp_stat_t stat;
    logic     item_ready;
    logic     result_valid;

    fpfa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_is_req  (item.data.operation == OP_REQUEST),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    fpfa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .item_word   (item.data),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .result_word (result.data)
    );

    assign item.ready   = item_ready;
    assign result.valid = result_valid;
    assign cfg.ready    = 1'b1;

endmodule

// ===== hdl/fpfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences item intake, the partition table scan and the commit of a result.
// ----------------------------------------------------------------------------
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     item_is_req,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        item_ready     = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.item_take = 1'b1;
                    state_next    = item_is_req ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

`ifndef SYNTH
    a_rise_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_COMMIT)
        else $error("result word raised outside a commit");
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && stat.scan_done |=> state_reg == ST_COMMIT)
        else $error("finished scan did not move to commit");
    a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.item_take |=> state_reg != ST_IDLE)
        else $error("taken word did not start work");
`endif

endmodule

// ===== hdl/fpfa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator datapath
// Partition size memory, occupancy flags, fit search and running totals.
// ----------------------------------------------------------------------------
module fpfa_datapath
    import fpfa_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_cmd_t               cmd,
    output dp_stat_t               stat,
    input  in_word_t               item_word,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output out_word_t              result_word
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;

    logic [SIZE_BITS-1:0]  block_sizes_mem [MAX_BLOCKS];

    logic [STRAT_W-1:0]    strategy_reg;
    logic [BCOUNT_W-1:0]   block_count_reg;
    logic [OP_W-1:0]       op_reg;
    logic [IDX_FIELD_W-1:0] idx_reg;
    logic [SIZE_BITS-1:0]  want_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [SIZE_BITS-1:0]  rd_data_reg;
    logic                  pick_found_reg;
    logic [IDX_W-1:0]      pick_idx_reg;
    logic [SIZE_BITS-1:0]  pick_size_reg;
    logic [MAX_BLOCKS-1:0] occupied_reg;
    logic [TOTAL_W-1:0]    sum_reg;
    logic [TOTAL_W-1:0]    sum_next;
    logic [COUNT_W-1:0]    refused_reg;
    logic [COUNT_W-1:0]    refused_next;
    out_word_t             result_reg;

    logic [CNT_W-1:0]      limit;
    logic                  load_ok;
    logic                  strat_ok;
    logic                  cand;
    logic                  take;
    logic                  grant;
    logic [SIZE_BITS-1:0]  frag_full;
    logic [SUM_W-1:0]      sum_ext;

    always_comb
    begin
        if (int'(block_count_reg) > MAX_BLOCKS)
        begin
            limit = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            limit = CNT_W'(block_count_reg);
        end
    end

    assign stat.scan_done = (cnt_reg == limit);
    assign load_ok  = int'(idx_reg) < MAX_BLOCKS;
    assign strat_ok = (strategy_reg == STRAT_BEST) || (strategy_reg == STRAT_FIRST) ||
                      (strategy_reg == STRAT_WORST);
    assign cand     = rd_valid_reg && strat_ok && !occupied_reg[rd_idx_reg] &&
                      (rd_data_reg >= want_reg);

    always_comb
    begin
        take = 1'b0;
        if (cand)
        begin
            priority if (!pick_found_reg)
            begin
                take = 1'b1;
            end
            else if (strategy_reg == STRAT_BEST)
            begin
                take = rd_data_reg < pick_size_reg;
            end
            else if (strategy_reg == STRAT_WORST)
            begin
                take = rd_data_reg > pick_size_reg;
            end
            else
            begin
                take = 1'b0;
            end
        end
    end

    assign grant     = (op_reg == OP_REQUEST) && pick_found_reg;
    assign frag_full = grant ? (pick_size_reg - want_reg) : '0;
    assign sum_ext   = SUM_W'(sum_reg) + SUM_W'(frag_full);

    always_comb
    begin
        sum_next     = sum_reg;
        refused_next = refused_reg;
        if (op_reg == OP_CLEAR)
        begin
            sum_next     = '0;
            refused_next = '0;
        end
        else if (grant)
        begin
            sum_next = (sum_ext > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
        end
        else if ((op_reg == OP_REQUEST) && (refused_reg != REFUSED_MAX))
        begin
            refused_next = refused_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg    <= '0;
            block_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STRATEGY:    strategy_reg    <= cfg_data[STRAT_W-1:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data[BCOUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_take)
        begin
            op_reg   <= item_word.operation;
            idx_reg  <= item_word.block_index;
            want_reg <= SIZE_BITS'(item_word.size);
        end
        if (cmd.scan_step)
        begin
            rd_idx_reg  <= cnt_reg[IDX_W-1:0];
            rd_data_reg <= block_sizes_mem[cnt_reg[IDX_W-1:0]];
        end
        if (cmd.commit && (op_reg == OP_LOAD) && load_ok)
        begin
            block_sizes_mem[IDX_W'(idx_reg)] <= want_reg;
        end
        if (take)
        begin
            pick_idx_reg  <= rd_idx_reg;
            pick_size_reg <= rd_data_reg;
        end
        if (cmd.commit)
        begin
            result_reg.granted             <= grant;
            result_reg.granted_block       <= grant ? IDX_FIELD_W'(pick_idx_reg) : '0;
            result_reg.fragmentation       <= SIZE_W'(frag_full);
            result_reg.total_fragmentation <= sum_next;
            result_reg.unallocated_count   <= refused_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            pick_found_reg <= 1'b0;
            occupied_reg   <= '0;
            sum_reg        <= '0;
            refused_reg    <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.item_take)
            begin
                cnt_reg        <= '0;
                pick_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (take)
                begin
                    pick_found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                sum_reg     <= sum_next;
                refused_reg <= refused_next;
                if (op_reg == OP_CLEAR)
                begin
                    occupied_reg <= '0;
                end
                else if (grant)
                begin
                    occupied_reg[pick_idx_reg] <= 1'b1;
                end
            end
        end
    end

    assign result_word = result_reg;

`ifndef SYNTH
    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        pick_found_reg |-> pick_size_reg >= want_reg)
        else $error("chosen partition is smaller than the request");
    a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && grant |-> !occupied_reg[pick_idx_reg])
        else $error("grant of an occupied partition");
    a_clear_totals: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && op_reg == OP_CLEAR |=> sum_reg == '0 && refused_reg == '0)
        else $error("clear left running totals");
    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> int'(rd_idx_reg) < MAX_BLOCKS)
        else $error("scan read beyond the partition table");
`endif

endmodule
